/* hw/rtl/page_frame_allocator_oldest_victim_macros.svh */
// assertion macros for the frame allocator
`ifndef PAGE_FRAME_ALLOCATOR_OLDEST_VICTIM_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_OLDEST_VICTIM_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame allocator check failed");
// next-cycle implication
`define PFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame allocator check failed");
`else
`define PFA_ASSERT_NOW(label, ante, cons)
`define PFA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hw/rtl/pfa_pkg.sv */
package pfa_pkg;

    localparam int FRAMES    = 128;
    localparam int PAGE_BITS = 8;
    localparam int STAMP_W   = 32;
    localparam int IDX_W     = $clog2(FRAMES);
    localparam int CNT_W     = $clog2(FRAMES + 1);

    localparam logic [7:0] FRAMES_RESET = 8'd128;

    // search record handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic                 free;
        logic                 have_best;
        logic [IDX_W-1:0]     idx;
        logic [STAMP_W-1:0]   stamp;
        logic [PAGE_BITS-1:0] page;
    } t_cand;

    // broadcast update of the chosen frame
    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [PAGE_BITS-1:0] page;
        logic [STAMP_W-1:0]   stamp;
    } t_wr;

endpackage

/* hw/rtl/pfa_cell.sv */
module pfa_cell
    import pfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [CNT_W-1:0] i_active,
    input  t_cand            i_cand,
    input  t_wr              i_wr,
    output t_cand            o_cand
);

    logic                 r_used;
    logic [PAGE_BITS-1:0] r_page;
    logic [STAMP_W-1:0]   r_stamp;
    t_cand                r_cand;
    t_cand                n_cand;
    logic                 w_examine;
    logic                 w_hit;

    assign w_examine = CNT_W'(i_idx) < i_active;
    assign w_hit     = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_cand = i_cand;
        if (i_cand.valid && w_examine && !i_cand.free) begin
            if (!r_used) begin
                n_cand.free = 1'b1;
                n_cand.idx  = i_idx;
            end else if (!i_cand.have_best || (r_stamp < i_cand.stamp)) begin
                // strict compare keeps the lowest index on equal stamps
                n_cand.have_best = 1'b1;
                n_cand.idx       = i_idx;
                n_cand.stamp     = r_stamp;
                n_cand.page      = r_page;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
            if (w_hit) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_page  <= i_wr.page;
            r_stamp <= i_wr.stamp;
        end
    end

    assign o_cand = r_cand;

endmodule

/* hw/rtl/page_frame_allocator_oldest_victim.sv */
// result path: the start transfer loads the record register of frame cell zero, the record
//   walks the cell registers of the chain, and the write-back updates the chosen frame and fills the result registers
// requests: no new request is taken while one is open; busy drops with the result strobe and the next
//   start transfer can follow on the edge that ends it
// reset: synchronous active-low i_rst_n clears used bits, load counter and output strobe at once;
//   frames_in_use returns to 128; no clearing pass
// the receiver cannot stall: o_valid marks each result for exactly one cycle
`include "page_frame_allocator_oldest_victim_macros.svh"

module page_frame_allocator_oldest_victim
    import pfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_page_number,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_valid,
    output logic [6:0] o_frame_index,
    output logic       o_evicted,
    output logic [7:0] o_evicted_page
);

    // control registers
    logic               r_busy;
    logic [7:0]         r_frames_in_use;
    logic [STAMP_W-1:0] r_seq;
    logic               r_valid;

    // payload registers
    logic [7:0]         r_page;
    logic [6:0]         r_frame_index;
    logic               r_evicted;
    logic [7:0]         r_evicted_page;

    logic               w_accept;
    logic [CNT_W-1:0]   w_active;
    t_cand              w_seed;
    t_cand              w_chain [FRAMES];
    t_cand              w_tail;
    t_wr                w_wr;

    assign w_accept = start && !r_busy;

    // frame count clamped to 1..FRAMES
    always_comb begin
        if (r_frames_in_use == 8'd0) begin
            w_active = CNT_W'(1);
        end else if (32'(r_frames_in_use) > FRAMES) begin
            w_active = CNT_W'(FRAMES);
        end else begin
            w_active = CNT_W'(r_frames_in_use);
        end
    end

    // empty search record enters cell zero on the start transfer
    always_comb begin
        w_seed       = '0;
        w_seed.valid = w_accept;
    end

    // search chain: the record moves one frame cell per cycle, each cell
    // in the frame count may claim it as the first free frame or as the oldest stamp so far
    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        pfa_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_idx    (IDX_W'(k)),
            .i_active (w_active),
            .i_cand   ((k == 0) ? w_seed : w_chain[(k == 0) ? 0 : k - 1]),
            .i_wr     (w_wr),
            .o_cand   (w_chain[k])
        );
    end

    assign w_tail = w_chain[FRAMES-1];

    // write-back: chosen frame takes the new page and the current stamp
    always_comb begin
        w_wr.en    = w_tail.valid;
        w_wr.idx   = w_tail.idx;
        w_wr.page  = PAGE_BITS'(r_page);
        w_wr.stamp = r_seq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_frames_in_use <= FRAMES_RESET;
            r_seq           <= '0;
            r_valid         <= 1'b0;
        end else begin
            r_valid <= w_tail.valid;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            // load counter saturates at all ones
            if (w_tail.valid && (r_seq != '1)) begin
                r_seq <= r_seq + STAMP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page_number;
        end
        if (w_tail.valid) begin
            r_frame_index  <= 7'(w_tail.idx);
            r_evicted      <= !w_tail.free;
            r_evicted_page <= w_tail.free ? 8'd0 : 8'(w_tail.page);
        end
    end

    assign busy           = r_busy;
    assign o_valid        = r_valid;
    assign o_frame_index  = r_frame_index;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_evicted_page;

    // a start transfer always leaves the block busy
    `PFA_ASSERT_NEXT(a_accept_busy, w_accept, r_busy)
    // the search record only reaches the tail while a request is open
    `PFA_ASSERT_NOW(a_tail_in_busy, w_tail.valid, r_busy)
    // result strobe never stays high back to back
    `PFA_ASSERT_NEXT(a_strobe_single, r_valid, !r_valid)
    // a free-frame result reports no evicted page
    `PFA_ASSERT_NOW(a_free_no_page, r_valid && !r_evicted, r_evicted_page == 8'd0)

endmodule

/* tb/tb.sv */
module tb;
    import pfa_pkg::FRAMES;

    // run bounds: 612 loads, with plenty of margin
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned LOADS_PER_PHASE = 75;
    localparam int          NUM_PHASES      = 8;
    localparam int unsigned DRAIN_CYCLES    = 200;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned MAX_GAP         = 260;
    localparam logic [31:0] SEQ_CEILING     = 32'hFFFF_FFFF;

    // one grant as it appears on the result ports
    typedef struct packed {
        logic [6:0] frame;
        logic       evicted;
        logic [7:0] victim_page;
    } t_frame_grant;

    // kinds of rows in the directed table
    typedef enum bit {
        ROW_LOAD,
        ROW_FRAME_COUNT
    } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic [7:0]   value;
        bit           typed;
        t_frame_grant want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_page_number;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       o_valid;
    logic [6:0] o_frame_index;
    logic       o_evicted;
    logic [7:0] o_evicted_page;

    page_frame_allocator_oldest_victim u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_page_number  (i_page_number),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_frame_index  (o_frame_index),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page)
    );

    // shadow copy of the frame table, the load counter and the frame count register
    bit          shadow_used  [FRAMES];
    logic [7:0]  shadow_page  [FRAMES];
    logic [31:0] shadow_stamp [FRAMES];
    logic [31:0] shadow_seq;
    logic [7:0]  shadow_frame_count;

    // grants still owed by the block, oldest first
    t_frame_grant pending_grants[$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // directed part: typed grants only where they follow trivially from the history
    t_stim_row directed_rows[18] = '{
        // empty table after reset, lowest free frames taken in order
        '{ROW_LOAD,        8'h00, 1'b1, {7'd0, 1'b0, 8'h00}},
        '{ROW_LOAD,        8'hFF, 1'b1, {7'd1, 1'b0, 8'h00}},
        // two frames, both full: oldest load goes first
        '{ROW_FRAME_COUNT, 8'd2,  1'b0, '0},
        '{ROW_LOAD,        8'hA5, 1'b1, {7'd0, 1'b1, 8'h00}},
        '{ROW_LOAD,        8'h5A, 1'b1, {7'd1, 1'b1, 8'hFF}},
        // a count of zero behaves as a single frame
        '{ROW_FRAME_COUNT, 8'd0,  1'b0, '0},
        '{ROW_LOAD,        8'h3C, 1'b1, {7'd0, 1'b1, 8'hA5}},
        // same page again is simply reloaded
        '{ROW_LOAD,        8'h3C, 1'b1, {7'd0, 1'b1, 8'h3C}},
        // count grows: hidden frame 1 comes back, frames 2 and 3 are free
        '{ROW_FRAME_COUNT, 8'd4,  1'b0, '0},
        '{ROW_LOAD,        8'h3C, 1'b1, {7'd2, 1'b0, 8'h00}},
        '{ROW_LOAD,        8'h81, 1'b1, {7'd3, 1'b0, 8'h00}},
        '{ROW_LOAD,        8'h7E, 1'b0, '0},
        // count above the table size is clamped
        '{ROW_FRAME_COUNT, 8'd255, 1'b0, '0},
        '{ROW_LOAD,        8'h01, 1'b0, '0},
        '{ROW_FRAME_COUNT, 8'd128, 1'b0, '0},
        '{ROW_LOAD,        8'h02, 1'b0, '0},
        '{ROW_FRAME_COUNT, 8'd1,  1'b0, '0},
        '{ROW_LOAD,        8'h10, 1'b0, '0}
    };

    // frame count per random phase: small, full, clamped, zero and odd sizes
    logic [7:0] phase_frame_count[NUM_PHASES] = '{
        8'd3, 8'd128, 8'd255, 8'd1, 8'd0, 8'd2, 8'd17, 8'd128
    };

    // sender idle percentage per phase, cycling through the idling schemes
    int unsigned phase_idle_pct[4] = '{0, 51, 0, 33};

    // free-running clock, period 8
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // frame choice for one load: lowest free frame, else oldest stamp, lowest index on ties
    function automatic t_frame_grant grant_frame(logic [7:0] page);
        int           span;
        int           chosen;
        bit           found_free;
        t_frame_grant g;
        span = (shadow_frame_count == 8'd0) ? 1 :
               (shadow_frame_count > FRAMES) ? FRAMES : int'(shadow_frame_count);
        chosen = 0;
        found_free = 1'b0;
        g = '0;
        for (int i = 0; i < span; i++) begin
            if (!found_free && !shadow_used[i]) begin
                chosen = i;
                found_free = 1'b1;
            end
        end
        if (!found_free) begin
            for (int i = 1; i < span; i++) begin
                if (shadow_stamp[i] < shadow_stamp[chosen])
                    chosen = i;
            end
            g.evicted = 1'b1;
            g.victim_page = shadow_page[chosen];
        end
        g.frame = chosen[6:0];
        shadow_used[chosen] = 1'b1;
        shadow_page[chosen] = page;
        shadow_stamp[chosen] = shadow_seq;
        if (shadow_seq != SEQ_CEILING)
            shadow_seq = shadow_seq + 32'd1;
        return g;
    endfunction

    // drop start and hold off until the block is empty and idle
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_grants.size() != 0 || busy)
            @(negedge i_clk);
    endtask

    task automatic idle_for(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // register write, only once nothing is in flight
    task automatic set_frame_count(logic [7:0] value);
        drain_block();
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'($urandom_range(0, 255));
        shadow_frame_count = value;
    endtask

    // one load request; start stays high until the transfer, and after it for the caller
    task automatic request_load(logic [7:0] page, bit typed, t_frame_grant want);
        t_frame_grant g;
        @(negedge i_clk);
        start = 1'b1;
        i_page_number = page;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        g = grant_frame(page);
        if (typed)
            g = want;
        pending_grants.push_back(g);
    endtask

    // result side: every strobe must match the oldest owed grant
    always @(posedge i_clk) begin : grant_check
        t_frame_grant want;
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected grant: frame %0d evicted %0b page %02h",
                             o_frame_index, o_evicted, o_evicted_page);
            end else begin
                want = pending_grants.pop_front();
                if (want.frame !== o_frame_index || want.evicted !== o_evicted ||
                        want.victim_page !== o_evicted_page) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("grant mismatch: expected %0d/%0b/%02h got %0d/%0b/%02h",
                                 want.frame, want.evicted, want.victim_page,
                                 o_frame_index, o_evicted, o_evicted_page);
                end
            end
        end
    end

    initial begin
        int unsigned pct;
        // every input known from time zero, reset asserted before the directed table
        i_rst_n = 1'b0;
        start = 1'b0;
        i_page_number = 8'h00;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'h00;
        for (int i = 0; i < FRAMES; i++) begin
            shadow_used[i] = 1'b0;
            shadow_page[i] = 8'h00;
            shadow_stamp[i] = 32'h0;
        end
        shadow_seq = 32'h0;
        shadow_frame_count = 8'd128;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table, back to back
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_FRAME_COUNT)
                set_frame_count(directed_rows[r].value);
            else
                request_load(directed_rows[r].value, directed_rows[r].typed,
                             directed_rows[r].want);
        end

        // random phases: each sets a frame count, then streams random pages
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 6)
                set_frame_count(8'($urandom_range(5, 127)));
            else
                set_frame_count(phase_frame_count[ph]);
            pct = phase_idle_pct[ph % 4];
            for (int k = 0; k < LOADS_PER_PHASE; k++) begin
                // now and then wait for the block to empty completely
                if ($urandom_range(0, 39) == 0)
                    drain_block();
                else if ($urandom_range(0, 99) < pct)
                    idle_for($urandom_range(1, MAX_GAP));
                request_load(8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_cell.sv
hw/rtl/page_frame_allocator_oldest_victim.sv
tb/tb.sv
